// ===== hw/rtl/ddpsr_pkg.sv =====
// Shared constants for the differential-drive PI speed ramp unit.
// Direction codes, register indexes and configuration reset values.
// No dependencies.
package ddpsr_pkg;

    // Drive direction codes
    localparam logic [2:0] DIR_STOP     = 3'd0;
    localparam logic [2:0] DIR_FORWARD  = 3'd1;
    localparam logic [2:0] DIR_RIGHT    = 3'd2;
    localparam logic [2:0] DIR_LEFT     = 3'd3;
    localparam logic [2:0] DIR_BACKWARD = 3'd4;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CMD_TIMEOUT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP     = 2'd3;

    // Widest configuration register
    localparam int unsigned CFG_DATA_W = 16;

    // Reset values of the configuration registers
    localparam logic [7:0]  PROP_GAIN_RST     = 8'd5;
    localparam logic [15:0] INTEGRAL_GAIN_RST = 16'd0;
    localparam logic [15:0] CMD_TIMEOUT_RST   = 16'd2000;
    localparam logic [7:0]  RAMP_STEP_RST     = 8'd1;

    // Largest pwm level
    localparam int unsigned PWM_LEVEL_MAX_DEF = 255;

endpackage

// ===== hw/rtl/differential_drive_pi_speed_ramp_unit.sv =====
// Top level of the differential-drive PI speed ramp unit: a six-register pipeline.
// Depends on ddpsr_pkg (direction codes, register indexes, reset values).
//
// One request per control tick: commanded and measured wheel speeds, elapsed time and
// command age. The unit takes a new request every cycle unless in_stall is high, and returns
// one result per request, in order. The pipeline: input register, error and proportional
// product, integral update, integral product, PI sum and clamp, then the slew ramp in the output
// register. The integral sums update when a request enters the third register and the pwm
// levels when it enters the output register, each a loop closed within its own stage. A stall
// on the output holds the full stages behind it; empty stages keep filling. Configuration is
// written through cfg_we / cfg_index / cfg_data; the user must write it only while no request
// is in flight, which the block itself does not enforce.
module differential_drive_pi_speed_ramp_unit #(
    parameter int unsigned PWM_LEVEL_MAX = ddpsr_pkg::PWM_LEVEL_MAX_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [ddpsr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ddpsr_pkg::CFG_DATA_W-1:0]   cfg_data,
    // request channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [15:0]                 target_left,
    input  logic signed [15:0]                 target_right,
    input  logic signed [15:0]                 measured_left,
    input  logic signed [15:0]                 measured_right,
    input  logic [15:0]                        elapsed_ms,
    input  logic [15:0]                        command_age_ms,
    // result channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [2:0]                         drive_direction,
    output logic [15:0]                        left_duty,
    output logic [15:0]                        right_duty
);

    localparam logic [33:0] LVL_MAX_U = 34'(PWM_LEVEL_MAX);
    localparam logic [7:0]  LVL_MAX_B = 8'(PWM_LEVEL_MAX);
    localparam logic signed [34:0] SUM_MAX = 35'sh0_7FFF_FFFF;
    localparam logic signed [34:0] SUM_MIN = -35'sh0_8000_0000;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0]  prop_gain_reg;
    logic [15:0] integral_gain_reg;
    logic [15:0] cmd_timeout_reg;
    logic [7:0]  ramp_step_reg;

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg     <= ddpsr_pkg::PROP_GAIN_RST;
            integral_gain_reg <= ddpsr_pkg::INTEGRAL_GAIN_RST;
            cmd_timeout_reg   <= ddpsr_pkg::CMD_TIMEOUT_RST;
            ramp_step_reg     <= ddpsr_pkg::RAMP_STEP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ddpsr_pkg::REG_PROP_GAIN:     prop_gain_reg     <= cfg_data[7:0];
                ddpsr_pkg::REG_INTEGRAL_GAIN: integral_gain_reg <= cfg_data;
                ddpsr_pkg::REG_CMD_TIMEOUT:   cmd_timeout_reg   <= cfg_data;
                ddpsr_pkg::REG_RAMP_STEP:     ramp_step_reg     <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage takes new data when empty or when
    // the stage after it moves
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

    assign rdy6 = !v6_reg || !out_stall;
    assign rdy5 = !v5_reg || rdy6;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign in_stall  = !rdy1;
    assign out_valid = v6_reg;

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
            if (rdy6) v6_reg <= v5_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic signed [15:0] s1_tl_reg, s1_tr_reg, s1_ml_reg, s1_mr_reg;
    logic [15:0]        s1_elapsed_reg, s1_age_reg;

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            s1_tl_reg      <= target_left;
            s1_tr_reg      <= target_right;
            s1_ml_reg      <= measured_left;
            s1_mr_reg      <= measured_right;
            s1_elapsed_reg <= elapsed_ms;
            s1_age_reg     <= command_age_ms;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: speed errors, error times elapsed time, proportional term,
    // direction class and staleness
    // ------------------------------------------------------------------
    logic signed [16:0] abs_tl, abs_tr, abs_ml, abs_mr;
    logic signed [16:0] err_l, err_r;
    logic signed [16:0] elapsed_s;
    logic signed [8:0]  prop_s;
    logic signed [33:0] eprod_l, eprod_r;
    logic signed [25:0] pterm_l, pterm_r;
    logic [2:0]         dir_class;
    logic               tl_pos, tl_neg, tr_pos, tr_neg;

    always_comb
    begin
        abs_tl = s1_tl_reg[15] ? -17'(s1_tl_reg) : 17'(s1_tl_reg);
        abs_tr = s1_tr_reg[15] ? -17'(s1_tr_reg) : 17'(s1_tr_reg);
        abs_ml = s1_ml_reg[15] ? -17'(s1_ml_reg) : 17'(s1_ml_reg);
        abs_mr = s1_mr_reg[15] ? -17'(s1_mr_reg) : 17'(s1_mr_reg);
        err_l  = abs_tl - abs_ml;
        err_r  = abs_tr - abs_mr;
    end

    assign elapsed_s = $signed({1'b0, s1_elapsed_reg});
    assign prop_s    = $signed({1'b0, prop_gain_reg});
    assign eprod_l   = err_l * elapsed_s;
    assign eprod_r   = err_r * elapsed_s;
    assign pterm_l   = prop_s * err_l;
    assign pterm_r   = prop_s * err_r;

    // Classify the drive direction from the command signs
    assign tl_neg = s1_tl_reg[15];
    assign tr_neg = s1_tr_reg[15];
    assign tl_pos = !tl_neg && (s1_tl_reg != 16'sd0);
    assign tr_pos = !tr_neg && (s1_tr_reg != 16'sd0);

    always_comb
    begin
        if (tl_pos && tr_pos)
            dir_class = ddpsr_pkg::DIR_FORWARD;
        else if (tl_pos || (!tl_neg && tr_neg))
            dir_class = ddpsr_pkg::DIR_RIGHT;
        else if ((tl_neg && !tr_neg) || (!tl_neg && tr_pos))
            dir_class = ddpsr_pkg::DIR_LEFT;
        else if (tl_neg && tr_neg)
            dir_class = ddpsr_pkg::DIR_BACKWARD;
        else
            dir_class = ddpsr_pkg::DIR_STOP;
    end

    logic signed [33:0] s2_eprod_l_reg, s2_eprod_r_reg;
    logic signed [25:0] s2_pterm_l_reg, s2_pterm_r_reg;
    logic [2:0]         s2_dir_reg;
    logic               s2_stale_reg;

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            s2_eprod_l_reg <= eprod_l;
            s2_eprod_r_reg <= eprod_r;
            s2_pterm_l_reg <= pterm_l;
            s2_pterm_r_reg <= pterm_r;
            s2_dir_reg     <= dir_class;
            s2_stale_reg   <= (s1_age_reg > cmd_timeout_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: integral update with saturation; clear on stop or on a
    // change of direction
    // ------------------------------------------------------------------
    logic signed [31:0] left_sum_reg, right_sum_reg, left_sum_next, right_sum_next;
    logic [2:0]         last_dir_reg;
    logic signed [34:0] raw_l, raw_r;
    logic signed [31:0] sat_l, sat_r;
    logic               dir_reset;
    logic               s3_load;

    assign s3_load = rdy3 && v2_reg;
    assign raw_l   = 35'(left_sum_reg) + 35'(s2_eprod_l_reg);
    assign raw_r   = 35'(right_sum_reg) + 35'(s2_eprod_r_reg);

    always_comb
    begin
        if (raw_l > SUM_MAX)
            sat_l = 32'sh7FFF_FFFF;
        else if (raw_l < SUM_MIN)
            sat_l = -32'sh8000_0000;
        else
            sat_l = raw_l[31:0];
        if (raw_r > SUM_MAX)
            sat_r = 32'sh7FFF_FFFF;
        else if (raw_r < SUM_MIN)
            sat_r = -32'sh8000_0000;
        else
            sat_r = raw_r[31:0];
    end

    assign dir_reset      = (s2_dir_reg == ddpsr_pkg::DIR_STOP) || (s2_dir_reg != last_dir_reg);
    assign left_sum_next  = dir_reset ? 32'sd0 : sat_l;
    assign right_sum_next = dir_reset ? 32'sd0 : sat_r;

    // Hold the integrals and the last direction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_sum_reg  <= 32'sd0;
            right_sum_reg <= 32'sd0;
            last_dir_reg  <= ddpsr_pkg::DIR_STOP;
        end
        else if (s3_load)
        begin
            left_sum_reg  <= left_sum_next;
            right_sum_reg <= right_sum_next;
            last_dir_reg  <= s2_dir_reg;
        end
    end

    logic signed [31:0] s3_sat_l_reg, s3_sat_r_reg;
    logic signed [25:0] s3_pterm_l_reg, s3_pterm_r_reg;
    logic [2:0]         s3_dir_reg;
    logic               s3_zero_reg;

    always_ff @(posedge clk)
    begin
        if (s3_load)
        begin
            s3_sat_l_reg   <= sat_l;
            s3_sat_r_reg   <= sat_r;
            s3_pterm_l_reg <= s2_pterm_l_reg;
            s3_pterm_r_reg <= s2_pterm_r_reg;
            s3_dir_reg     <= s2_dir_reg;
            s3_zero_reg    <= dir_reset || s2_stale_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: integral gain times integral
    // ------------------------------------------------------------------
    logic signed [16:0] igain_s;
    logic signed [48:0] iprod_l, iprod_r;

    assign igain_s = $signed({1'b0, integral_gain_reg});
    assign iprod_l = igain_s * s3_sat_l_reg;
    assign iprod_r = igain_s * s3_sat_r_reg;

    logic signed [48:0] s4_iprod_l_reg, s4_iprod_r_reg;
    logic signed [25:0] s4_pterm_l_reg, s4_pterm_r_reg;
    logic [2:0]         s4_dir_reg;
    logic               s4_zero_reg;

    always_ff @(posedge clk)
    begin
        if (rdy4 && v3_reg)
        begin
            s4_iprod_l_reg <= iprod_l;
            s4_iprod_r_reg <= iprod_r;
            s4_pterm_l_reg <= s3_pterm_l_reg;
            s4_pterm_r_reg <= s3_pterm_r_reg;
            s4_dir_reg     <= s3_dir_reg;
            s4_zero_reg    <= s3_zero_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: PI sum (floor of the Q16 integral term), magnitude, clamp
    // ------------------------------------------------------------------
    logic signed [33:0] u_l, u_r;
    logic [33:0]        mag_l, mag_r;
    logic [7:0]         req_l, req_r;

    assign u_l   = 34'(s4_pterm_l_reg) + 34'($signed(s4_iprod_l_reg[48:16]));
    assign u_r   = 34'(s4_pterm_r_reg) + 34'($signed(s4_iprod_r_reg[48:16]));
    assign mag_l = u_l[33] ? 34'(-u_l) : 34'(u_l);
    assign mag_r = u_r[33] ? 34'(-u_r) : 34'(u_r);

    always_comb
    begin
        if (s4_zero_reg)
            req_l = 8'd0;
        else if (mag_l > LVL_MAX_U)
            req_l = LVL_MAX_B;
        else
            req_l = mag_l[7:0];
        if (s4_zero_reg)
            req_r = 8'd0;
        else if (mag_r > LVL_MAX_U)
            req_r = LVL_MAX_B;
        else
            req_r = mag_r[7:0];
    end

    logic [7:0] s5_req_l_reg, s5_req_r_reg;
    logic [2:0] s5_dir_reg;

    always_ff @(posedge clk)
    begin
        if (rdy5 && v4_reg)
        begin
            s5_req_l_reg <= req_l;
            s5_req_r_reg <= req_r;
            s5_dir_reg   <= s4_dir_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: slew-limited level update and output register
    // ------------------------------------------------------------------
    logic [7:0] left_level_reg, right_level_reg, left_level_next, right_level_next;
    logic [7:0] ramp_l, ramp_r;
    logic [7:0] diff_l, diff_r;
    logic       s6_load;

    assign s6_load = rdy6 && v5_reg;

    // Step each level toward its request by at most the ramp step
    always_comb
    begin
        diff_l = 8'd0;
        diff_r = 8'd0;
        ramp_l = left_level_reg;
        ramp_r = right_level_reg;
        if (s5_req_l_reg > left_level_reg)
        begin
            diff_l = s5_req_l_reg - left_level_reg;
            ramp_l = (diff_l > ramp_step_reg) ? left_level_reg + ramp_step_reg : s5_req_l_reg;
        end
        else if (s5_req_l_reg < left_level_reg)
        begin
            diff_l = left_level_reg - s5_req_l_reg;
            ramp_l = (diff_l > ramp_step_reg) ? left_level_reg - ramp_step_reg : s5_req_l_reg;
        end
        if (s5_req_r_reg > right_level_reg)
        begin
            diff_r = s5_req_r_reg - right_level_reg;
            ramp_r = (diff_r > ramp_step_reg) ? right_level_reg + ramp_step_reg : s5_req_r_reg;
        end
        else if (s5_req_r_reg < right_level_reg)
        begin
            diff_r = right_level_reg - s5_req_r_reg;
            ramp_r = (diff_r > ramp_step_reg) ? right_level_reg - ramp_step_reg : s5_req_r_reg;
        end
        left_level_next  = (ramp_l > LVL_MAX_B) ? LVL_MAX_B : ramp_l;
        right_level_next = (ramp_r > LVL_MAX_B) ? LVL_MAX_B : ramp_r;
    end

    // Hold the pwm levels
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_level_reg  <= 8'd0;
            right_level_reg <= 8'd0;
        end
        else if (s6_load)
        begin
            left_level_reg  <= left_level_next;
            right_level_reg <= right_level_next;
        end
    end

    logic stopped;
    assign stopped = (s5_dir_reg == ddpsr_pkg::DIR_STOP);

    // Load the result; duty is level times 257, zero while stopped
    always_ff @(posedge clk)
    begin
        if (s6_load)
        begin
            drive_direction <= s5_dir_reg;
            left_duty       <= stopped ? 16'd0 : {left_level_next, left_level_next};
            right_duty      <= stopped ? 16'd0 : {right_level_next, right_level_next};
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (left_level_reg <= LVL_MAX_B) && (right_level_reg <= LVL_MAX_B))
        else $error("pwm level above its bound");

    a_stop_clears_sums: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_load && (s2_dir_reg == ddpsr_pkg::DIR_STOP))
        |=> (left_sum_reg == 32'sd0) && (right_sum_reg == 32'sd0))
        else $error("integrals not cleared on stop");

    a_stop_zero_duty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (drive_direction == ddpsr_pkg::DIR_STOP))
        |-> (left_duty == 16'd0) && (right_duty == 16'd0))
        else $error("nonzero duty while stopped");

    a_level_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !s6_load |=> $stable(left_level_reg) && $stable(right_level_reg))
        else $error("pwm level moved without a result");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> v1_reg && v2_reg && v3_reg && v4_reg && v5_reg && v6_reg && out_stall)
        else $error("input stalled with room in the pipeline");

endmodule

// ===== tb/testbench.sv =====
// Testbench for differential_drive_pi_speed_ramp_unit: directed ticks, then random drive segments.
// A scoreboard class predicts direction and duties per tick; depends on ddpsr_pkg and the unit.
`timescale 1ns / 1ps

module testbench;

    typedef struct {
        logic [2:0]  direction;
        logic [15:0] left_duty;
        logic [15:0] right_duty;
    } duty_result_t;

    // Tracks controller state per accepted tick and checks duties in order
    class speed_ramp_checker;
        bit [7:0]     prop_gain;
        bit [15:0]    integral_gain;
        bit [15:0]    command_timeout;
        bit [7:0]     ramp_step;
        int           left_level;
        int           right_level;
        int           left_sum;
        int           right_sum;
        logic [2:0]   last_direction;
        duty_result_t pending_duties[$];
        int           failures;

        function new();
            prop_gain       = ddpsr_pkg::PROP_GAIN_RST;
            integral_gain   = ddpsr_pkg::INTEGRAL_GAIN_RST;
            command_timeout = ddpsr_pkg::CMD_TIMEOUT_RST;
            ramp_step       = ddpsr_pkg::RAMP_STEP_RST;
            left_level      = 0;
            right_level     = 0;
            left_sum        = 0;
            right_sum       = 0;
            last_direction  = ddpsr_pkg::DIR_STOP;
            failures        = 0;
        endfunction

        function void set_register(logic [ddpsr_pkg::CFG_IDX_W-1:0] index,
                                   logic [15:0] value);
            case (index)
                ddpsr_pkg::REG_PROP_GAIN:     prop_gain       = value[7:0];
                ddpsr_pkg::REG_INTEGRAL_GAIN: integral_gain   = value;
                ddpsr_pkg::REG_CMD_TIMEOUT:   command_timeout = value;
                ddpsr_pkg::REG_RAMP_STEP:     ramp_step       = value[7:0];
                default:                      ;
            endcase
        endfunction

        // Update one wheel's error sum and return its clamped PI request
        function int wheel_request(int target, int measured, int elapsed, inout int error_sum);
            longint err;
            longint acc;
            longint u;
            err = longint'(target < 0 ? -target : target)
                - longint'(measured < 0 ? -measured : measured);
            acc = longint'(error_sum) + err * longint'(elapsed);
            if (acc > 64'sd2147483647)
                acc = 64'sd2147483647;
            if (acc < -64'sd2147483648)
                acc = -64'sd2147483648;
            error_sum = int'(acc);
            // arithmetic shift gives floor division by 65536
            u = longint'(prop_gain) * err + ((longint'(integral_gain) * acc) >>> 16);
            if (u < 0)
                u = -u;
            if (u > ddpsr_pkg::PWM_LEVEL_MAX_DEF)
                u = ddpsr_pkg::PWM_LEVEL_MAX_DEF;
            return int'(u);
        endfunction

        // Move a level toward its request by at most one ramp step
        function int ramp_level(int level, int req);
            int step;
            step = int'(ramp_step);
            if (req > level)
                level = (req - level > step) ? level + step : req;
            else if (req < level)
                level = (level - req > step) ? level - step : req;
            if (level > ddpsr_pkg::PWM_LEVEL_MAX_DEF)
                level = ddpsr_pkg::PWM_LEVEL_MAX_DEF;
            if (level < 0)
                level = 0;
            return level;
        endfunction

        function void note_tick(logic signed [15:0] tl, logic signed [15:0] tr,
                                logic signed [15:0] ml, logic signed [15:0] mr,
                                logic [15:0] elapsed, logic [15:0] age);
            int           req_l;
            int           req_r;
            int           sl;
            int           sr;
            logic [2:0]   dir;
            duty_result_t r;
            req_l = wheel_request(int'(tl), int'(ml), int'(elapsed), left_sum);
            req_r = wheel_request(int'(tr), int'(mr), int'(elapsed), right_sum);
            sl = int'(tl);
            sr = int'(tr);
            // classify from command signs
            if (sl > 0 && sr > 0)
                dir = ddpsr_pkg::DIR_FORWARD;
            else if ((sl > 0 && sr <= 0) || (sl == 0 && sr < 0))
                dir = ddpsr_pkg::DIR_RIGHT;
            else if ((sl < 0 && sr >= 0) || (sl == 0 && sr > 0))
                dir = ddpsr_pkg::DIR_LEFT;
            else if (sl < 0 && sr < 0)
                dir = ddpsr_pkg::DIR_BACKWARD;
            else
                dir = ddpsr_pkg::DIR_STOP;
            // stop or direction change: drop requests and clear integrals
            if (dir == ddpsr_pkg::DIR_STOP || dir != last_direction)
            begin
                last_direction = dir;
                req_l = 0;
                req_r = 0;
                left_sum = 0;
                right_sum = 0;
            end
            // stale command: drop requests, keep integrals
            if (age > command_timeout)
            begin
                req_l = 0;
                req_r = 0;
            end
            left_level  = ramp_level(left_level, req_l);
            right_level = ramp_level(right_level, req_r);
            r.direction  = dir;
            r.left_duty  = (dir == ddpsr_pkg::DIR_STOP) ? 16'd0 : 16'(left_level * 257);
            r.right_duty = (dir == ddpsr_pkg::DIR_STOP) ? 16'd0 : 16'(right_level * 257);
            pending_duties.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_duty(logic [2:0] dir, logic [15:0] ld, logic [15:0] rd);
            duty_result_t want;
            if (pending_duties.size() == 0)
            begin
                $error("unexpected result: direction %0d, left %0d, right %0d", dir, ld, rd);
                failures++;
                return;
            end
            want = pending_duties.pop_front();
            compare_field("drive_direction", 16'(want.direction), 16'(dir));
            compare_field("left_duty", want.left_duty, ld);
            compare_field("right_duty", want.right_duty, rd);
        endfunction

        function int pending();
            return pending_duties.size();
        endfunction
    endclass

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             cfg_we;
    logic [ddpsr_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ddpsr_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                             in_valid;
    logic                             in_stall;
    logic signed [15:0]               target_left;
    logic signed [15:0]               target_right;
    logic signed [15:0]               measured_left;
    logic signed [15:0]               measured_right;
    logic [15:0]                      elapsed_ms;
    logic [15:0]                      command_age_ms;
    logic                             out_valid;
    logic                             out_stall;
    logic [2:0]                       drive_direction;
    logic [15:0]                      left_duty;
    logic [15:0]                      right_duty;
    bit                               quiet_tail = 1'b0;

    speed_ramp_checker ramp_model = new();

    always #4 clk = ~clk;

    differential_drive_pi_speed_ramp_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .target_left    (target_left),
        .target_right   (target_right),
        .measured_left  (measured_left),
        .measured_right (measured_right),
        .elapsed_ms     (elapsed_ms),
        .command_age_ms (command_age_ms),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .drive_direction(drive_direction),
        .left_duty      (left_duty),
        .right_duty     (right_duty)
    );

    // Check every accepted result
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            ramp_model.check_duty(drive_direction, left_duty, right_duty);
    end

    // Stall the result side in random bursts
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet_tail && $urandom_range(0, 9) == 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 8)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    // Send one request and hold it until accepted; returns at a falling edge
    task automatic send_tick(input logic signed [15:0] tl, input logic signed [15:0] tr,
                             input logic signed [15:0] ml, input logic signed [15:0] mr,
                             input logic [15:0] el, input logic [15:0] age);
        if (!quiet_tail && $urandom_range(0, 7) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        target_left    = tl;
        target_right   = tr;
        measured_left  = ml;
        measured_right = mr;
        elapsed_ms     = el;
        command_age_ms = age;
        in_valid       = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        ramp_model.note_tick(tl, tr, ml, mr, el, age);
        @(negedge clk);
    endtask

    // Drop valid and wait until every pending duty has come back
    task automatic wait_idle();
        in_valid = 1'b0;
        while (ramp_model.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_register(input logic [ddpsr_pkg::CFG_IDX_W-1:0] index,
                                  input logic [15:0] value);
        cfg_index = index;
        cfg_data  = value;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
        ramp_model.set_register(index, value);
    endtask

    task automatic apply_settings(input int prop, input int igain, input int timeout,
                                  input int step);
        wait_idle();
        write_register(ddpsr_pkg::REG_PROP_GAIN, 16'(prop));
        write_register(ddpsr_pkg::REG_INTEGRAL_GAIN, 16'(igain));
        write_register(ddpsr_pkg::REG_CMD_TIMEOUT, 16'(timeout));
        write_register(ddpsr_pkg::REG_RAMP_STEP, 16'(step));
    endtask

    // Commanded speed with a given sign, mostly small magnitudes
    function automatic logic signed [15:0] pick_speed(int sgn);
        int mag;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: mag = $urandom_range(1, 64);
            5, 6, 7:       mag = $urandom_range(1, 3000);
            default:       mag = $urandom_range(1, 32768);
        endcase
        if (sgn > 0 && mag > 32767)
            mag = 32767;
        return 16'(sgn * mag);
    endfunction

    // Measured speed near the command, or anything
    function automatic logic signed [15:0] pick_measured(logic signed [15:0] target);
        if ($urandom_range(0, 1) == 0)
            return 16'(int'(target) + int'($urandom_range(0, 40)) - 20);
        return 16'($urandom);
    endfunction

    // Drive segments of steady direction with random content, plus some noise
    task automatic run_phase(input int count);
        int                 done;
        int                 len;
        int                 sl;
        int                 sr;
        logic signed [15:0] tl;
        logic signed [15:0] tr;
        logic [15:0]        el;
        logic [15:0]        age;
        done = 0;
        while (done < count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_tick(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom));
                done++;
            end
            else
            begin
                sl  = int'($urandom_range(0, 2)) - 1;
                sr  = int'($urandom_range(0, 2)) - 1;
                len = $urandom_range(1, 40);
                tl  = pick_speed(sl);
                tr  = pick_speed(sr);
                for (int i = 0; i < len && done < count; i++)
                begin
                    if ($urandom_range(0, 4) == 0)
                    begin
                        tl = pick_speed(sl);
                        tr = pick_speed(sr);
                    end
                    case ($urandom_range(0, 9))
                        7, 8:    el = 16'($urandom_range(0, 2000));
                        9:       el = 16'($urandom);
                        default: el = 16'($urandom_range(1, 50));
                    endcase
                    case ($urandom_range(0, 19))
                        0:       age = 16'($urandom);
                        1:       age = ramp_model.command_timeout;
                        2:       age = ramp_model.command_timeout + 16'd1;
                        default: age = 16'($urandom_range(0, ramp_model.command_timeout));
                    endcase
                    send_tick(tl, tr, pick_measured(tl), pick_measured(tr), el, age);
                    done++;
                end
            end
        end
    endtask

    // Give up on a hung run
    initial
    begin
        #3ms;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = ddpsr_pkg::REG_PROP_GAIN;
        cfg_data       = '0;
        in_valid       = 1'b0;
        target_left    = '0;
        target_right   = '0;
        measured_left  = '0;
        measured_right = '0;
        elapsed_ms     = '0;
        command_age_ms = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Direction classes and field extremes under reset settings
        send_tick(0, 0, 0, 0, 10, 0);
        send_tick(100, 100, 0, 0, 10, 0);
        send_tick(100, 100, 0, 0, 10, 0);
        send_tick(32767, -32768, 0, 0, 65535, 65535);
        send_tick(0, -1, 0, 0, 1, 0);
        send_tick(1, 0, 0, 0, 1, 0);
        send_tick(-1, 0, 0, 0, 1, 0);
        send_tick(0, 1, 0, 0, 1, 0);
        send_tick(-32768, 32767, -32768, 32767, 5, 2000);
        send_tick(-5, -5, 0, 0, 5, 0);
        // stale command keeps the integrals
        send_tick(-32768, -32768, 32767, -32768, 65535, 2001);
        send_tick(-32768, -32768, 0, 0, 1, 0);
        send_tick(0, 0, -1, -1, 0, 0);

        // Drive both integrals into positive saturation, then the left one into negative saturation
        apply_settings(1, 65535, 65535, 255);
        send_tick(-32768, -32768, 0, 0, 65535, 0);
        send_tick(-32768, -32768, 0, 0, 65535, 0);
        send_tick(-32768, -32768, 0, 0, 65535, 0);
        send_tick(0, 1, -32768, 0, 65535, 0);
        send_tick(0, 1, -32768, 0, 65535, 0);
        send_tick(0, 1, -32768, 0, 65535, 0);

        // Zero ramp step freezes the levels
        apply_settings(1, 65535, 65535, 0);
        send_tick(0, 1, -32768, 0, 65535, 0);
        send_tick(0, 1, 0, 0, 1, 0);

        // Zero timeout: any age above it is stale
        apply_settings(1, 65535, 0, 255);
        send_tick(0, 1, 0, 0, 1, 1);
        send_tick(0, 1, 0, 0, 1, 0);

        // Random segments over several settings
        apply_settings(5, 200, 2000, 3);
        run_phase(200);
        apply_settings(0, 0, 65535, 1);
        run_phase(150);
        apply_settings(255, 65535, 0, 255);
        run_phase(150);
        repeat (4)
        begin
            apply_settings($urandom_range(0, 20), $urandom_range(0, 5000),
                           $urandom_range(0, 3000), $urandom_range(1, 16));
            run_phase(130);
        end
        apply_settings(6, 800, 2000, 0);
        run_phase(40);

        // Final stretch at full rate on both sides
        apply_settings(3, 1000, 500, 2);
        quiet_tail = 1'b1;
        run_phase(150);

        wait_idle();
        repeat (12) @(negedge clk);
        if (ramp_model.failures == 0 && ramp_model.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
